// ===== rtl/gmps_pkg.sv =====
// shared types, widths and helpers for the grid minimum path sum block
// no dependencies; every other file of the block uses it
`timescale 1ns / 1ps
`default_nettype none

package gmps_pkg;

  localparam int COST_W       = 16;
  localparam int SUM_W        = 32;
  localparam int ROWS_W       = 16;
  localparam int COLS_W       = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int DEF_MAX_COLS = 1024;

  typedef logic [COST_W-1:0]     cost_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [ROWS_W-1:0]     rows_t;
  typedef logic [COLS_W-1:0]     cols_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_NUM_ROWS = cfg_idx_t'(0);
  localparam cfg_idx_t REG_NUM_COLS = cfg_idx_t'(1);

  localparam sum_t SUM_MAX = '1;

  typedef struct packed {
    sum_t path_sum;
    logic is_last;
  } result_t;

  // per-cell control of the row chain
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  function automatic sum_t sat_add(input sum_t a, input cost_t b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W + 1 - COST_W){1'b0}}, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gmps_if.sv =====
// valid/ready channel interfaces for cell costs and path sum results
// depends on gmps_pkg
`timescale 1ns / 1ps
`default_nettype none

interface gmps_in_if;
  logic            valid;
  logic            ready;
  gmps_pkg::cost_t cell_cost;

  modport source (output valid, output cell_cost, input ready);
  modport sink   (input valid, input cell_cost, output ready);
endinterface

interface gmps_out_if;
  logic           valid;
  logic           ready;
  gmps_pkg::sum_t path_sum;
  logic           is_last;

  modport source (output valid, output path_sum, output is_last, input ready);
  modport sink   (input valid, input path_sum, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/gmps_cell.sv =====
// one cell of the row chain: holds one sum of the row buffer
// depends on gmps_pkg
`timescale 1ns / 1ps
`default_nettype none

module gmps_cell (
  input  wire                  clk,
  input  gmps_pkg::cell_ctl_t  ctl,
  input  gmps_pkg::sum_t       next_val,
  input  gmps_pkg::sum_t       new_val,
  output gmps_pkg::sum_t       val
);
  import gmps_pkg::*;

  sum_t val_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      val_r <= ctl.load ? new_val : next_val;
    end
  end

  assign val = val_r;

endmodule

`default_nettype wire

// ===== rtl/gmps_row_chain.sv =====
// row buffer as a chain of cells shifting toward cell 0 once per item
// new sums enter at the cell one short of the row length; depends on gmps_pkg, gmps_cell
`timescale 1ns / 1ps
`default_nettype none

module gmps_row_chain #(
  parameter int MAX_COLS = gmps_pkg::DEF_MAX_COLS
) (
  input  wire                          clk,
  input  wire                          shift_en,
  input  wire [$clog2(MAX_COLS)-1:0]   ins_pos,
  input  gmps_pkg::sum_t               new_val,
  output gmps_pkg::sum_t               head_val
);
  import gmps_pkg::*;

  localparam int CW = $clog2(MAX_COLS);

  sum_t      vals  [MAX_COLS];
  sum_t      nexts [MAX_COLS];
  cell_ctl_t ctls  [MAX_COLS];

  for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
    assign ctls[k].shift = shift_en;
    assign ctls[k].load  = (ins_pos == CW'(k));

    if (k == MAX_COLS - 1) begin : g_tail
      assign nexts[k] = new_val;
    end else begin : g_body
      assign nexts[k] = vals[k+1];
    end

    gmps_cell u_cell (
      .clk      (clk),
      .ctl      (ctls[k]),
      .next_val (nexts[k]),
      .new_val  (new_val),
      .val      (vals[k])
    );
  end

  // sum of the same column in the previous row
  assign head_val = vals[0];

endmodule

`default_nettype wire

// ===== rtl/gmps_out_buf.sv =====
// output register plus skid slot for result items
// depends on gmps_pkg, gmps_out_if
`timescale 1ns / 1ps
`default_nettype none

module gmps_out_buf (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 res_valid,
  input  gmps_pkg::result_t   res,
  output logic                res_ready,
  gmps_out_if.source          out_ch
);
  import gmps_pkg::*;

  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;
  logic    out_take;
  logic    res_take;

  assign out_take  = out_valid_r && out_ch.ready;
  assign res_ready = !skid_valid_r;
  assign res_take  = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res_take) begin
      if (!out_valid_r || out_take) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.path_sum = out_data_r.path_sum;
  assign out_ch.is_last  = out_data_r.is_last;

endmodule

`default_nettype wire

// ===== rtl/grid_min_path_sum.sv =====
// top level of the grid minimum path sum block: position tracking, sum datapath
// depends on gmps_pkg, gmps_if, gmps_row_chain, gmps_out_buf
//
//   channel   dir  handshake         payload
//   in_ch     in   valid/ready       cell_cost[15:0]
//   out_ch    out  valid/ready       path_sum[31:0], is_last
//   cfg_*     in   cfg_we only       cfg_index[1:0], cfg_wdata[15:0]
//
// one item per cycle while in_ch.ready is high; each result is registered in the output buffer
// the rate is set by the loop through the left sum register and the head cell of the row chain
// synchronous active-low reset clears position, left sum and handshake state; no clearing pass
// in_ch.ready drops only while the skid slot holds a result the sink has not taken
// a register write restarts the grid at the top-left cell
`timescale 1ns / 1ps
`default_nettype none

module grid_min_path_sum #(
  parameter int MAX_COLS = gmps_pkg::DEF_MAX_COLS
) (
  input  wire                   clk,
  input  wire                   rst_n,
  gmps_in_if.sink               in_ch,
  gmps_out_if.source            out_ch,
  input  wire                   cfg_we,
  input  gmps_pkg::cfg_idx_t    cfg_index,
  input  gmps_pkg::cfg_data_t   cfg_wdata
);
  import gmps_pkg::*;

  localparam int CW = $clog2(MAX_COLS);

  rows_t         num_rows_r;
  cols_t         num_cols_r;
  sum_t          left_sum_r;
  logic [CW-1:0] col_pos_r;
  rows_t         row_pos_r;

  logic [31:0]   cols_ext;
  logic [31:0]   cols_eff;
  logic [CW-1:0] last_col;
  rows_t         last_row;

  logic          accept;
  logic          buf_ready;
  sum_t          up_sum;
  sum_t          base;
  sum_t          sum;
  result_t       res;
  logic          at_last_col;
  logic          at_last_row;

  // effective grid size: zero acts as one, columns capped at the chain length
  always_comb begin
    cols_ext = 32'(num_cols_r);
    if (cols_ext == 32'd0) begin
      cols_eff = 32'd1;
    end else if (cols_ext > 32'(MAX_COLS)) begin
      cols_eff = 32'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
    last_col = CW'(cols_eff - 32'd1);
    last_row = (num_rows_r == '0) ? '0 : num_rows_r - rows_t'(1);
  end

  assign in_ch.ready = buf_ready;
  assign accept      = in_ch.valid && buf_ready;
  assign at_last_col = (col_pos_r == last_col);
  assign at_last_row = (row_pos_r == last_row);

  always_comb begin
    if (row_pos_r == '0 && col_pos_r == '0) begin
      base = '0;
    end else if (row_pos_r == '0) begin
      base = left_sum_r;
    end else if (col_pos_r == '0) begin
      base = up_sum;
    end else begin
      base = (up_sum < left_sum_r) ? up_sum : left_sum_r;
    end
    sum          = sat_add(base, in_ch.cell_cost);
    res.path_sum = sum;
    res.is_last  = at_last_row && at_last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= rows_t'(1);
      num_cols_r <= cols_t'(1);
      left_sum_r <= '0;
      col_pos_r  <= '0;
      row_pos_r  <= '0;
    end else if (cfg_we && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS)) begin
      if (cfg_index == REG_NUM_ROWS) begin
        num_rows_r <= rows_t'(cfg_wdata);
      end else begin
        num_cols_r <= cfg_wdata[COLS_W-1:0];
      end
      left_sum_r <= '0;
      col_pos_r  <= '0;
      row_pos_r  <= '0;
    end else if (accept) begin
      left_sum_r <= sum;
      if (at_last_col) begin
        col_pos_r <= '0;
        row_pos_r <= at_last_row ? '0 : row_pos_r + rows_t'(1);
      end else begin
        col_pos_r <= col_pos_r + CW'(1);
      end
    end
  end

  gmps_row_chain #(
    .MAX_COLS (MAX_COLS)
  ) u_row_chain (
    .clk      (clk),
    .shift_en (accept),
    .ins_pos  (last_col),
    .new_val  (sum),
    .head_val (up_sum)
  );

  gmps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (in_ch.valid),
    .res       (res),
    .res_ready (buf_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== dv/grid_min_path_sum_tb.sv =====
// self-checking testbench for grid_min_path_sum: directed table, then random grids
// depends on rtl/gmps_pkg.sv, rtl/gmps_if.sv and the grid_min_path_sum rtl
`timescale 1ns / 1ps

module grid_min_path_sum_tb;
  import gmps_pkg::*;

  localparam int MAX_COLS       = DEF_MAX_COLS;
  localparam int RANDOM_ITEMS   = 480;
  localparam int WATCHDOG_LIMIT = 2000;

  // indexes with no register behind them
  localparam cfg_idx_t REG_SPARE_A = cfg_idx_t'(2);
  localparam cfg_idx_t REG_SPARE_B = cfg_idx_t'(3);

  typedef enum logic {STEP_CELL, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    cfg_idx_t   idx;
    cfg_data_t  data;
    logic       known;
    sum_t       exp_sum;
    logic       exp_last;
  } dir_step_t;

  localparam int N_DIRECTED = 26;
  localparam dir_step_t DIRECTED [N_DIRECTED] = '{
    // power-on size is one cell, so every item is a whole grid
    '{STEP_CELL,  REG_NUM_ROWS, 16'd0,    1'b1, 32'd0,     1'b1},
    '{STEP_CELL,  REG_NUM_ROWS, 16'hFFFF, 1'b1, 32'd65535, 1'b1},
    // zero sizes act as one; only the low 11 bits of num_cols land
    '{STEP_WRITE, REG_NUM_ROWS, 16'd0,    1'b0, 32'd0,     1'b0},
    '{STEP_WRITE, REG_NUM_COLS, 16'h0800, 1'b0, 32'd0,     1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'd123,  1'b1, 32'd123,   1'b1},
    // textbook 3x3 grid, answer 7
    '{STEP_WRITE, REG_NUM_ROWS, 16'd3,    1'b0, 32'd0,     1'b0},
    '{STEP_WRITE, REG_NUM_COLS, 16'd3,    1'b0, 32'd0,     1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'd1,    1'b1, 32'd1,     1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'd3,    1'b0, 32'd0,     1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'd1,    1'b0, 32'd0,     1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'd1,    1'b0, 32'd0,     1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'd5,    1'b0, 32'd0,     1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'd1,    1'b0, 32'd0,     1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'd4,    1'b0, 32'd0,     1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'd2,    1'b0, 32'd0,     1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'd1,    1'b1, 32'd7,     1'b1},
    '{STEP_WRITE, REG_SPARE_A,  16'hFFFF, 1'b0, 32'd0,     1'b0},
    // 2x3, abandoned mid-row by a write that restarts the grid as 2x2
    '{STEP_WRITE, REG_NUM_ROWS, 16'd2,    1'b0, 32'd0,     1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'hFFFF, 1'b1, 32'd65535, 1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'hFFFF, 1'b0, 32'd0,     1'b0},
    '{STEP_WRITE, REG_NUM_COLS, 16'd2,    1'b0, 32'd0,     1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'd10,   1'b1, 32'd10,    1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'd20,   1'b1, 32'd30,    1'b0},
    '{STEP_WRITE, REG_SPARE_B,  16'hFFFF, 1'b0, 32'd0,     1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'd5,    1'b1, 32'd15,    1'b0},
    '{STEP_CELL,  REG_NUM_ROWS, 16'hFFFF, 1'b0, 32'd0,     1'b0}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      src_valid = 1'b0;
  cost_t     src_cost = '0;
  logic      sink_ready = 1'b0;
  logic      cfg_we = 1'b0;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_wdata = '0;

  gmps_in_if  in_if ();
  gmps_out_if out_if ();

  assign in_if.valid     = src_valid;
  assign in_if.cell_cost = src_cost;
  assign out_if.ready    = sink_ready;

  grid_min_path_sum DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  rows_t       reg_rows = rows_t'(1);
  cols_t       reg_cols = cols_t'(1);
  sum_t        prev_row_sums [MAX_COLS];
  sum_t        left_sum_q = '0;
  int unsigned cur_col = 0;
  int unsigned cur_row = 0;

  result_t     pending_sums [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          idle_en = 1'b1;

  function automatic int unsigned grid_height();
    return (reg_rows == 0) ? 1 : reg_rows;
  endfunction

  function automatic int unsigned grid_width();
    if (reg_cols == 0) return 1;
    if (reg_cols > MAX_COLS) return MAX_COLS;
    return reg_cols;
  endfunction

  function automatic void apply_reg_write(input cfg_idx_t idx, input cfg_data_t data);
    if (idx == REG_NUM_ROWS) reg_rows = rows_t'(data);
    else if (idx == REG_NUM_COLS) reg_cols = cols_t'(data);
    else return;
    cur_col = 0;
    cur_row = 0;
    left_sum_q = '0;
  endfunction

  function automatic result_t predict_cell_sum(input cost_t cost);
    int unsigned    n_rows;
    int unsigned    n_cols;
    int unsigned    col;
    int unsigned    row;
    sum_t           base;
    sum_t           above;
    logic [SUM_W:0] wide;
    result_t        res;
    n_rows = grid_height();
    n_cols = grid_width();
    col = (cur_col < n_cols) ? cur_col : 0;
    row = (cur_row < n_rows) ? cur_row : 0;
    above = prev_row_sums[col];
    if (row == 0) base = (col == 0) ? sum_t'(0) : left_sum_q;
    else if (col == 0) base = above;
    else base = (above < left_sum_q) ? above : left_sum_q;
    wide = {1'b0, base} + {{(SUM_W + 1 - COST_W){1'b0}}, cost};
    res.path_sum = wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
    res.is_last  = (row == n_rows - 1) && (col == n_cols - 1);
    prev_row_sums[col] = res.path_sum;
    left_sum_q = res.path_sum;
    col++;
    if (col >= n_cols) begin
      col = 0;
      row++;
      if (row >= n_rows) row = 0;
    end
    cur_col = col;
    cur_row = row;
    return res;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cost_t pick_cost();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return cost_t'($urandom_range(0, 15));
      default: return cost_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic cfg_data_t pick_rows();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return cfg_data_t'(1);
      2: return cfg_data_t'($urandom_range(0, 65535));
      3: return '1;
      default: return cfg_data_t'($urandom_range(2, 6));
    endcase
  endfunction

  function automatic cfg_data_t pick_cols();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return cfg_data_t'(1);
      2: return cfg_data_t'($urandom_range(0, 65535));
      // upper bits fall outside the register
      3: return cfg_data_t'(16'hF800 | $urandom_range(1, 8));
      default: return cfg_data_t'($urandom_range(2, 8));
    endcase
  endfunction

  task automatic send_cell(input cost_t cost, input bit typed, input result_t typed_res);
    int      gap;
    result_t pred;
    gap = pick_gap();
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_cost  <= cost;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pred = predict_cell_sum(cost);
    pending_sums.push_back(typed ? typed_res : pred);
  endtask

  task automatic wait_all_results();
    src_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    wait_all_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg_write(idx, data);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      sink_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: result with none expected: path_sum %0d is_last %0b",
                 $time, out_if.path_sum, out_if.is_last);
        mismatches++;
      end else begin
        want = pending_sums.pop_front();
        if (out_if.path_sum !== want.path_sum) begin
          $display("%0t: path_sum expected %0d actual %0d",
                   $time, want.path_sum, out_if.path_sum);
          mismatches++;
        end
        if (out_if.is_last !== want.is_last) begin
          $display("%0t: is_last expected %0b actual %0b",
                   $time, want.is_last, out_if.is_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no item moved for %0d cycles", $time, quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          cells_sent;
    int unsigned area;
    int          n;
    cells_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == STEP_WRITE) begin
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        send_cell(cost_t'(DIRECTED[i].data), DIRECTED[i].known,
                  '{path_sum: DIRECTED[i].exp_sum, is_last: DIRECTED[i].exp_last});
      end
    end

    // random sizes, mostly whole grids; partial grids get cut by the next write
    while (cells_sent < RANDOM_ITEMS) begin
      idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) write_reg(REG_NUM_ROWS, pick_rows());
      if ($urandom_range(0, 2) != 0) write_reg(REG_NUM_COLS, pick_cols());
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  cfg_data_t'($urandom_range(0, 65535)));
      area = grid_height() * grid_width();
      if (area <= 48) begin
        n = area * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, area);
      end else begin
        n = $urandom_range(1, 48);
      end
      if (n > RANDOM_ITEMS - cells_sent) n = RANDOM_ITEMS - cells_sent;
      for (int i = 0; i < n; i++) begin
        send_cell(pick_cost(), 1'b0, '0);
        if ($urandom_range(0, 39) == 0) wait_all_results();
        cells_sent++;
      end
    end

    wait_all_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
